// ===== design/earliest_deadline_event_table_macros.svh =====
// assertion macros shared by the checker
`ifndef EARLIEST_DEADLINE_EVENT_TABLE_MACROS_SVH
`define EARLIEST_DEADLINE_EVENT_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define EDET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EDET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/edet_pkg.sv =====
`default_nettype none
package edet_pkg;

  localparam int NUM_HANDLERS = 32;
  localparam int IDX_W = $clog2(NUM_HANDLERS);
  localparam int DL_W = 48;

  localparam logic signed [DL_W-1:0] DL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DL_W-1:0] DL_MIN = 48'sh8000_0000_0000;
  localparam logic [DL_W-1:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0] CPU_RESET = 8'd25;

  localparam logic [2:0] CMD_ARM_CYC = 3'd0;
  localparam logic [2:0] CMD_ARM_US  = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_ACK     = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  handler;
    logic [39:0] delay;
    logic [31:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [4:0]             next_handler;
    logic signed [DL_W-1:0] next_time;
    logic                   handler_armed;
  } result_t;

  function automatic logic handler_ok(input logic [4:0] h);
    logic [6:0] w;
    w = {2'b00, h};
    return (int'(w) < NUM_HANDLERS);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [4:0] h);
    logic [6:0] w;
    w = {2'b00, h};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [4:0] to_handler(input logic [IDX_W-1:0] i);
    logic [6:0] w;
    w = 7'(i);
    return w[4:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/earliest_deadline_event_table.sv =====
`default_nettype none
// channel   signals                         beat taken when
// command   start, busy, item               start && !busy
// result    done, result                    done (one cycle, receiver cannot stall)
// config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// the result strobe follows the command beat through a setup state (ST_PREP) and a sweep
// state (ST_SWEEP) that reads one table entry per cycle through the memory read port
// busy drops with the strobe and the next beat can be taken at the edge that
// ends it, so a new command is taken only after the previous result is out
// rst (synchronous) clears the marks, the current index and the accumulator and
// reloads the rate register; the deadline memory needs no clearing
module earliest_deadline_event_table (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire edet_pkg::item_t  item,
  output logic                  done,
  output edet_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  localparam int N = edet_pkg::NUM_HANDLERS;
  localparam int IW = edet_pkg::IDX_W;
  localparam int DW = edet_pkg::DL_W;

  edet_pkg::state_t state, state_next;

  logic [2:0]             cmd;
  logic [4:0]             handler;
  logic [39:0]            delay;
  logic [DW-1:0]          acc;
  logic [7:0]             cycles_per_us;
  logic signed [DW-1:0]   arm_value;
  logic                   apply;
  logic [N-1:0]           marks;
  logic [IW-1:0]          cur_idx;
  logic [IW-1:0]          sweep_idx;
  logic signed [DW-1:0]   best;
  logic [IW-1:0]          best_idx;

  logic                   accept;
  logic                   is_arm;
  logic                   h_ok;
  logic [IW-1:0]          h_idx;
  logic [DW:0]            acc_sum;
  logic [DW-1:0]          prod;
  logic                   last;
  logic [IW-1:0]          raddr;
  logic [DW-1:0]          rdata;
  logic signed [DW+1:0]   diff;
  logic signed [DW-1:0]   dec_value;
  logic signed [DW-1:0]   new_value;
  logic                   hit_arm;
  logic                   dec;
  logic                   we;
  logic                   take;
  logic signed [DW-1:0]   best_fin;
  logic [IW-1:0]          idx_fin;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_arm    = (cmd == edet_pkg::CMD_ARM_CYC) || (cmd == edet_pkg::CMD_ARM_US);
  assign h_ok      = edet_pkg::handler_ok(handler);
  assign h_idx     = edet_pkg::to_idx(handler);
  assign acc_sum   = {1'b0, acc} + {17'd0, item.elapsed};
  assign prod      = {8'd0, delay} * {40'd0, cycles_per_us};
  assign last      = (sweep_idx == IW'(N - 1));

  // saturating countdown of one entry
  assign diff      = {{2{rdata[DW-1]}}, rdata} - {2'b00, acc};
  assign dec_value = (diff[DW+1] && (diff[DW:DW-1] != 2'b11)) ? edet_pkg::DL_MIN
                                                              : diff[DW-1:0];
  assign hit_arm   = is_arm && h_ok && (sweep_idx == h_idx);
  assign dec       = apply && marks[sweep_idx];
  assign new_value = hit_arm ? arm_value : (dec ? dec_value : $signed(rdata));
  assign take      = marks[sweep_idx] && (sweep_idx != '0) && (new_value < best);
  assign best_fin  = take ? new_value : best;
  assign idx_fin   = take ? sweep_idx : best_idx;

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    raddr      = '0;
    we         = 1'b0;
    unique case (state)
      edet_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = edet_pkg::ST_PREP;
        end
      end
      edet_pkg::ST_PREP: begin
        state_next = edet_pkg::ST_SWEEP;
      end
      edet_pkg::ST_SWEEP: begin
        raddr = last ? '0 : IW'(sweep_idx + 1'b1);
        we    = hit_arm || dec;
        if (last) begin
          state_next = edet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = edet_pkg::ST_IDLE;
      end
    endcase
  end

  edet_ram #(
    .WIDTH(DW),
    .DEPTH(N)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(sweep_idx),
    .wdata(new_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      marks         <= '0;
      cur_idx       <= '0;
      acc           <= '0;
      cycles_per_us <= edet_pkg::CPU_RESET;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        cycles_per_us <= cfg_data;
      end
      if (accept) begin
        acc <= acc_sum[DW] ? edet_pkg::ACC_MAX : acc_sum[DW-1:0];
      end
      if (state == edet_pkg::ST_PREP) begin
        if (is_arm && h_ok) begin
          marks[h_idx] <= 1'b1;
        end else if ((cmd == edet_pkg::CMD_CANCEL) && h_ok) begin
          marks[h_idx] <= 1'b0;
        end else if (cmd == edet_pkg::CMD_ACK) begin
          marks[cur_idx] <= 1'b0;
        end
      end
      if ((state == edet_pkg::ST_SWEEP) && last) begin
        cur_idx <= idx_fin;
        done    <= 1'b1;
        if (apply) begin
          acc <= '0;
        end
      end
    end
  end

  // command payload and sweep datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= item.cmd;
      handler <= item.handler;
      delay   <= item.delay;
    end
    if (state == edet_pkg::ST_PREP) begin
      if (cmd == edet_pkg::CMD_ARM_US) begin
        arm_value <= prod[DW-1] ? edet_pkg::DL_MAX : $signed(prod);
      end else begin
        arm_value <= $signed({8'd0, delay});
      end
      apply     <= (is_arm && (cur_idx != '0)) || (cmd == edet_pkg::CMD_CANCEL)
                   || (cmd == edet_pkg::CMD_ACK);
      best      <= edet_pkg::DL_MAX;
      best_idx  <= '0;
      sweep_idx <= '0;
    end
    if (state == edet_pkg::ST_SWEEP) begin
      best      <= best_fin;
      best_idx  <= idx_fin;
      sweep_idx <= IW'(sweep_idx + 1'b1);
      if (last) begin
        result.next_handler  <= edet_pkg::to_handler(idx_fin);
        result.next_time     <= best_fin;
        result.handler_armed <= h_ok && marks[h_idx];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/edet_ram.sv =====
`default_nettype none
module edet_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/edet_checker.sv =====
`default_nettype none
`include "earliest_deadline_event_table_macros.svh"
module edet_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire edet_pkg::result_t result
);

  `EDET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not go busy")
  `EDET_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `EDET_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `EDET_ASSERT_NOW(a_fall_done, $fell(busy) && !$past(rst), done, "busy dropped with no result")
  `EDET_ASSERT_NOW(a_none_max, done && (result.next_handler == 5'd0),
                   result.next_time == edet_pkg::DL_MAX, "empty table with finite time")

endmodule

bind earliest_deadline_event_table edet_checker u_edet_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire

// ===== bench/earliest_deadline_event_table_tb.sv =====
module earliest_deadline_event_table_tb;
  import edet_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 267;
  localparam int NO_IDLE_PHASE = 2;
  localparam int TAIL_CYCLES = 2 * NUM_HANDLERS;

  typedef struct {
    item_t   it;
    bit      has_want;
    result_t want;
  } cmd_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   cmd_item = '0;
  logic    cfg_valid = 1'b0;
  logic    [7:0] cfg_data = 8'd0;
  logic    busy;
  logic    done;
  logic    cfg_ready;
  result_t result;

  // shadow of the table, kept in step with every accepted command
  logic signed [DL_W-1:0] deadline_mem [NUM_HANDLERS];
  logic                   armed_bit [NUM_HANDLERS];
  logic [4:0]             current_hdl;
  logic [DL_W-1:0]        elapsed_sum;
  logic [7:0]             rate_reg;

  result_t     due_events [$];
  cmd_row_t    directed_rows [$];
  int          mismatch_count = 0;
  int unsigned cycle_count;
  result_t     want;

  earliest_deadline_event_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (cmd_item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void age_deadlines();
    longint v;
    for (int i = 0; i < NUM_HANDLERS; i++) begin
      if (armed_bit[i]) begin
        v = deadline_mem[i];
        v = v - $signed({16'b0, elapsed_sum});
        deadline_mem[i] = (v < longint'(DL_MIN)) ? DL_MIN : v[DL_W-1:0];
      end
    end
    elapsed_sum = '0;
  endfunction

  function automatic result_t next_event_after(input item_t it);
    result_t            r;
    logic [DL_W:0]      sum;
    logic [DL_W-1:0]    prod;
    logic signed [DL_W-1:0] d;
    logic signed [DL_W-1:0] best;
    sum = {1'b0, elapsed_sum} + {17'b0, it.elapsed};
    elapsed_sum = sum[DL_W] ? ACC_MAX : sum[DL_W-1:0];
    case (it.cmd)
      CMD_ARM_CYC, CMD_ARM_US: begin
        d = {8'b0, it.delay};
        if (it.cmd == CMD_ARM_US) begin
          prod = {8'b0, it.delay} * {40'b0, rate_reg};
          d = prod[DL_W-1] ? DL_MAX : prod;
        end
        // with nothing current the elapsed count waits for later
        if (current_hdl != 0) age_deadlines();
        deadline_mem[it.handler] = d;
        armed_bit[it.handler] = 1'b1;
      end
      CMD_CANCEL: begin
        age_deadlines();
        armed_bit[it.handler] = 1'b0;
      end
      CMD_ACK: begin
        age_deadlines();
        armed_bit[current_hdl] = 1'b0;
      end
      default: ;
    endcase
    // slot 0 never wins, an entry at the greatest value never wins, ties go low
    best = DL_MAX;
    current_hdl = '0;
    for (int i = 1; i < NUM_HANDLERS; i++) begin
      if (armed_bit[i] && deadline_mem[i] < best) begin
        best = deadline_mem[i];
        current_hdl = 5'(i);
      end
    end
    r.next_handler = current_hdl;
    r.next_time = (current_hdl != 0) ? deadline_mem[current_hdl] : DL_MAX;
    r.handler_armed = armed_bit[it.handler];
    return r;
  endfunction

  function automatic cmd_row_t mk_row(input logic [2:0] cmd, input logic [4:0] h,
                                      input logic [39:0] d, input logic [31:0] el,
                                      input bit has, input logic [4:0] wh,
                                      input logic signed [DL_W-1:0] wt, input logic wa);
    cmd_row_t row;
    row.it.cmd = cmd;
    row.it.handler = h;
    row.it.delay = d;
    row.it.elapsed = el;
    row.has_want = has;
    row.want.next_handler = wh;
    row.want.next_time = wt;
    row.want.handler_armed = wa;
    return row;
  endfunction

  function automatic cmd_row_t random_row();
    cmd_row_t row;
    int sel;
    row.has_want = 1'b0;
    row.want = '0;
    sel = $urandom_range(0, 99);
    if (sel < 30) row.it.cmd = CMD_ARM_CYC;
    else if (sel < 45) row.it.cmd = CMD_ARM_US;
    else if (sel < 60) row.it.cmd = CMD_CANCEL;
    else if (sel < 80) row.it.cmd = CMD_ACK;
    else if (sel < 92) row.it.cmd = CMD_QUERY;
    else row.it.cmd = CMD_QUERY + 3'($urandom_range(1, 3));
    // a few busy handlers make cancels and queries hit armed entries
    if ($urandom_range(0, 99) < 60) row.it.handler = 5'($urandom_range(1, 7));
    else row.it.handler = 5'($urandom_range(0, NUM_HANDLERS - 1));
    case ($urandom_range(0, 9))
      0: row.it.delay = '0;
      1: row.it.delay = '1;
      2, 3: row.it.delay = 40'({$urandom, $urandom});
      default: row.it.delay = 40'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0: row.it.elapsed = '0;
      1: row.it.elapsed = '1;
      2: row.it.elapsed = $urandom;
      default: row.it.elapsed = 32'($urandom_range(0, 63));
    endcase
    return row;
  endfunction

  // start stays high across back-to-back beats; only a gap or drain_results lowers it
  task automatic send_cmd(input cmd_row_t row, input bit idle_ok);
    int      gap;
    result_t got;
    gap = 0;
    if (idle_ok && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 70);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd_item <= row.it;
    do @(posedge clk); while (busy);
    got = next_event_after(row.it);
    due_events.push_back(row.has_want ? row.want : got);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_reg = v;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_events.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatch_count++;
      end else begin
        want = due_events.pop_front();
        if (result.next_handler !== want.next_handler) begin
          $error("next_handler: expected %0d, got %0d", want.next_handler,
                 result.next_handler);
          mismatch_count++;
        end
        if (result.next_time !== want.next_time) begin
          $error("next_time: expected %0d, got %0d", want.next_time, result.next_time);
          mismatch_count++;
        end
        if (result.handler_armed !== want.handler_armed) begin
          $error("handler_armed: expected %0d, got %0d", want.handler_armed,
                 result.handler_armed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [7:0] r;
    for (int i = 0; i < NUM_HANDLERS; i++) begin
      deadline_mem[i] = DL_MAX;
      armed_bit[i] = 1'b0;
    end
    current_hdl = '0;
    elapsed_sum = '0;
    rate_reg = CPU_RESET;

    directed_rows.push_back(mk_row(CMD_QUERY,   5'd5,  40'd0, 32'd0, 1, 5'd0, DL_MAX, 1'b0));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd3,  40'd100, 32'd10, 1, 5'd3, 48'sd100, 1'b1));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd7,  40'd50, 32'd5, 1, 5'd7, 48'sd50, 1'b1));
    directed_rows.push_back(mk_row(CMD_QUERY,   5'd3,  40'd0, 32'd0, 1, 5'd7, 48'sd50, 1'b1));
    directed_rows.push_back(mk_row(CMD_ARM_US,  5'd9,  40'd1, 32'd0, 1, 5'd9, 48'sd25, 1'b1));
    directed_rows.push_back(mk_row(CMD_ARM_US,  5'd10, '1, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_ACK,     5'd0,  40'd0, 32'd3, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_CANCEL,  5'd7,  40'd0, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_CANCEL,  5'd3,  40'd0, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_CANCEL,  5'd10, 40'd0, 32'd0, 1, 5'd0, DL_MAX, 1'b0));
    // null slot gets armed but is never current
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd0,  40'd0, 32'd0, 1, 5'd0, DL_MAX, 1'b1));
    directed_rows.push_back(mk_row(CMD_QUERY,   5'd0,  40'd0, 32'd0, 1, 5'd0, DL_MAX, 1'b1));
    // acknowledge with nothing current drops the null slot mark
    directed_rows.push_back(mk_row(CMD_ACK,     5'd0,  40'd0, 32'd0, 1, 5'd0, DL_MAX, 1'b0));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd31, '1, '1, 1, 5'd31,
                                   48'sh00FF_FFFF_FFFF, 1'b1));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd30, '1, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_QUERY + 3'd1, 5'd30, 40'd0, '1, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_QUERY + 3'd2, 5'd1, 40'd0, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_QUERY + 3'd3, 5'd31, 40'd0, 32'd0, 0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd20, 40'd5, 32'd0, 0, '0, '0, 1'b0));
    // tie on deadline, lower index wins
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd13, 40'd5, 32'd0, 1, 5'd13, 48'sd5, 1'b1));
    directed_rows.push_back(mk_row(CMD_ARM_US,  5'd14, 40'd0, 32'd0, 1, 5'd14, 48'sd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_ACK,     5'd14, 40'd0, 32'd0, 1, 5'd13, 48'sd5, 1'b0));
    directed_rows.push_back(mk_row(CMD_ARM_CYC, 5'd5,  40'd2, 32'd10, 0, '0, '0, 1'b0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_rate(CPU_RESET);
    foreach (directed_rows[i]) send_cmd(directed_rows[i], 1'b1);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: r = 8'd0;
        1: r = 8'd1;
        2: r = 8'hFF;
        NUM_PHASES - 1: r = CPU_RESET;
        default: r = 8'($urandom_range(2, 254));
      endcase
      write_rate(r);
      repeat (ITEMS_PER_PHASE) send_cmd(random_row(), p != NO_IDLE_PHASE);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/edet_pkg.sv
design/edet_ram.sv
design/earliest_deadline_event_table.sv
design/edet_checker.sv
bench/earliest_deadline_event_table_tb.sv
